// ===== sv/rvx_pkg.sv =====
package rvx_pkg;

  localparam int unsigned MemBytesDefault = 65536;

  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcJal    = 7'h6F;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcSystem = 7'h73;

  localparam logic [6:0] F7Base   = 7'h00;
  localparam logic [6:0] F7Alt    = 7'h20;
  localparam logic [6:0] F7MulDiv = 7'h01;
  localparam logic [6:0] F7DivU   = 7'h05;

  localparam logic [2:0] F3AddSub = 3'd0;
  localparam logic [2:0] F3Sll    = 3'd1;
  localparam logic [2:0] F3Slt    = 3'd2;
  localparam logic [2:0] F3Sltu   = 3'd3;
  localparam logic [2:0] F3Xor    = 3'd4;
  localparam logic [2:0] F3Sr     = 3'd5;
  localparam logic [2:0] F3Or     = 3'd6;
  localparam logic [2:0] F3And    = 3'd7;

  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  localparam logic [2:0] F3Priv = 3'd0;

  localparam logic [4:0] RegRa = 5'd1;
  localparam logic [4:0] RegSp = 5'd2;
  localparam logic [4:0] RegA0 = 5'd10;
  localparam logic [4:0] RegA1 = 5'd11;

  typedef enum logic [1:0] {
    MduMul  = 2'd0,
    MduDivS = 2'd1,
    MduDivU = 2'd2
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

endpackage

// ===== sv/rv64_integer_instruction_executor_core.sv =====
// RV64 integer executor: one instruction word is taken per request at the current pc and
// one result is returned per request. ALU, branch, jump, LUI/AUIPC and SYSTEM instructions
// go through accept, register read and execute, and commit, which waits for a free output
// register. Loads and stores add one byte at a time in SLd/SLdw or SSt, since the data
// memory is a single byte-wide RAM. MUL, DIV, DIVU, REM and REMU run on the shared
// iterative multiply/divide unit (one bit per cycle) unless the divisor is zero; when
// MEM_BYTES is not a power of two every load and store with funct3 bit 2 clear also uses
// that unit to reduce its address modulo MEM_BYTES. After reset the data memory is cleared
// byte by byte before the first request is taken; code_size writes are accepted at any
// time. A finished result waits in the output register while the next request is taken.
module rv64_integer_instruction_executor_core import rvx_pkg::*; #(
  parameter int unsigned MEM_BYTES = MemBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instruction_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        next_pc_o,
  output logic               halted_o,
  output logic               dest_written_o,
  output logic [4:0]         dest_index_o,
  output logic signed [63:0] dest_value_o,
  output logic signed [63:0] return_value_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam bit IsPow2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
  localparam logic [AW:0]   MemEnd  = (AW+1)'(MEM_BYTES);
  localparam logic [AW-1:0] MemLast = AW'(MEM_BYTES - 1);
  localparam logic [63:0]   MemSize = 64'(MEM_BYTES);

  typedef enum logic [9:0] {
    SClear = 10'b0000000001,
    SIdle  = 10'b0000000010,
    SExec  = 10'b0000000100,
    SMdu   = 10'b0000001000,
    SX11   = 10'b0000010000,
    SMaddr = 10'b0000100000,
    SLd    = 10'b0001000000,
    SLdw   = 10'b0010000000,
    SSt    = 10'b0100000000,
    SFin   = 10'b1000000000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] inst_q, inst_d;
  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;
  logic [31:0] code_size_q;
  logic [63:0] a0_q, a0_d;
  logic [31:0] rf_valid_q;
  logic        wr_q, wr_d;
  logic        stop_q, stop_d;
  logic [63:0] val_q, val_d;
  logic [63:0] x11_q, x11_d;
  logic [31:0] npc_q, npc_d;
  logic [63:0] b_q, b_d;
  logic        is_mul_q, is_mul_d;
  logic        is_load_q, is_load_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [AW-1:0] baddr_q, baddr_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] o_npc_q, o_npc_d;
  logic        o_halt_q, o_halt_d;
  logic        o_wr_q, o_wr_d;
  logic [4:0]  o_idx_q, o_idx_d;
  logic [63:0] o_val_q, o_val_d;
  logic [63:0] o_a0_q, o_a0_d;

  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [63:0] rs1_val, rs2_val, op_b, eff_i, eff_s, merged;
  logic [63:0] rdata_a, rdata_b;
  logic [5:0]  shamt;
  logic        use_sra, taken;
  logic [2:0]  last_cnt;
  logic [AW:0] addr_inc;
  logic [AW-1:0] addr_nxt;

  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr_a, rf_raddr_b;
  logic [63:0] rf_wdata;

  logic          dm_we;
  logic [7:0]    dm_wdata, dm_rdata;
  mdu_req_t      mdu_req;
  mdu_rsp_t      mdu_rsp;
  logic [63:0]   mdu_a, mdu_b, mdu_quo, mdu_rem;
  logic          commit, pc_over;

  assign opc = inst_q[6:0];
  assign rd  = inst_q[11:7];
  assign f3  = inst_q[14:12];
  assign rs1 = inst_q[19:15];
  assign rs2 = inst_q[24:20];
  assign f7  = inst_q[31:25];

  assign imm_i = {{52{inst_q[31]}}, inst_q[31:20]};
  assign imm_s = {{52{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
  assign imm_b = {{51{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
  assign imm_j = {{43{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21],
                  1'b0};
  assign imm_u = {{32{inst_q[31]}}, inst_q[31:12], 12'b0};

  // unwritten registers read as their reset value
  assign rs1_val = rf_valid_q[rs1] ? rdata_a : ((rs1 == RegSp) ? MemSize : 64'd0);
  assign rs2_val = rf_valid_q[rs2] ? rdata_b : ((rs2 == RegSp) ? MemSize : 64'd0);
  assign op_b    = (opc == OpcOpImm) ? imm_i : rs2_val;
  assign shamt   = op_b[5:0];
  assign use_sra = (opc == OpcOp) ? (f7 != F7Base) : inst_q[30];
  assign eff_i   = rs1_val + imm_i;
  assign eff_s   = rs1_val + imm_s;

  assign last_cnt = {f3[1] & f3[0], f3[1], f3[1] | f3[0]};
  assign addr_inc = {1'b0, baddr_q} + {{AW{1'b0}}, 1'b1};
  assign addr_nxt = (addr_inc == MemEnd) ? '0 : addr_inc[AW-1:0];

  assign pc_over = ({1'b0, pc_q} + 33'd4) > {1'b0, code_size_q};
  assign commit  = !out_valid_q || out_ready_i;

  assign rf_raddr_a = (state_q == SIdle) ? instruction_i[19:15] : rs1;
  assign rf_raddr_b = (state_q == SIdle) ? instruction_i[24:20] : rs2;

  always_comb begin
    unique case (f3)
      F3Beq:   taken = (rs1_val == rs2_val);
      F3Bne:   taken = (rs1_val != rs2_val);
      F3Blt:   taken = ($signed(rs1_val) < $signed(rs2_val));
      F3Bge:   taken = !($signed(rs1_val) < $signed(rs2_val));
      F3Bltu:  taken = (rs1_val < rs2_val);
      F3Bgeu:  taken = (rs1_val >= rs2_val);
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    merged = val_q;
    merged[{cnt_q, 3'b000} +: 8] = dm_rdata;
  end

  always_comb begin
    state_d     = state_q;
    inst_d      = inst_q;
    pc_d        = pc_q;
    halt_d      = halt_q;
    a0_d        = a0_q;
    wr_d        = wr_q;
    stop_d      = stop_q;
    val_d       = val_q;
    x11_d       = x11_q;
    npc_d       = npc_q;
    b_d         = b_q;
    is_mul_d    = is_mul_q;
    is_load_d   = is_load_q;
    cnt_d       = cnt_q;
    baddr_d     = baddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_npc_d     = o_npc_q;
    o_halt_d    = o_halt_q;
    o_wr_d      = o_wr_q;
    o_idx_d     = o_idx_q;
    o_val_d     = o_val_q;
    o_a0_d      = o_a0_q;
    rf_we       = 1'b0;
    rf_waddr    = rd;
    rf_wdata    = val_q;
    dm_we       = 1'b0;
    dm_wdata    = b_q[{cnt_q, 3'b000} +: 8];
    mdu_req     = '{start: 1'b0, op: MduMul};
    mdu_a       = rs1_val;
    mdu_b       = rs2_val;

    unique case (state_q)
      SClear: begin
        dm_we    = 1'b1;
        dm_wdata = 8'd0;
        baddr_d  = addr_nxt;
        if (baddr_q == MemLast) begin
          baddr_d = '0;
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (in_valid_i) begin
          inst_d = instruction_i;
          wr_d   = 1'b0;
          val_d  = '0;
          if (halt_q || pc_over) begin
            stop_d  = 1'b1;
            state_d = SFin;
          end else begin
            stop_d  = 1'b0;
            state_d = SExec;
          end
        end
      end

      SExec: begin
        npc_d   = pc_q + 32'd4;
        wr_d    = 1'b0;
        val_d   = '0;
        b_d     = rs2_val;
        state_d = SFin;
        unique case (opc)
          OpcOp, OpcOpImm: begin
            wr_d = 1'b1;
            unique case (f3)
              F3AddSub: begin
                if (opc == OpcOpImm || f7 == F7Base) begin
                  val_d = rs1_val + op_b;
                end else if (f7 == F7Alt) begin
                  val_d = rs1_val - rs2_val;
                end else if (f7 == F7MulDiv) begin
                  mdu_req  = '{start: 1'b1, op: MduMul};
                  is_mul_d = 1'b1;
                  state_d  = SMdu;
                end
              end
              F3Sll:  val_d = rs1_val << shamt;
              F3Slt:  val_d = {63'd0, $signed(rs1_val) < $signed(op_b)};
              F3Sltu: val_d = {63'd0, rs1_val < op_b};
              F3Sr:   val_d = use_sra ? 64'($signed(rs1_val) >>> shamt) : (rs1_val >> shamt);
              F3Xor, F3Or: begin
                if (opc == OpcOp && (f7 == F7MulDiv || f7 == F7DivU)) begin
                  if (rs2_val == 64'd0) begin
                    // divide by zero: DIV forms also copy the dividend to x11
                    if (f3 == F3Xor) begin
                      val_d   = '1;
                      x11_d   = rs1_val;
                      state_d = SX11;
                    end else begin
                      val_d = rs1_val;
                    end
                  end else begin
                    mdu_req  = '{start: 1'b1, op: (f7 == F7MulDiv) ? MduDivS : MduDivU};
                    is_mul_d = 1'b0;
                    state_d  = SMdu;
                  end
                end else begin
                  val_d = (f3 == F3Xor) ? (rs1_val ^ op_b) : (rs1_val | op_b);
                end
              end
              default: val_d = rs1_val & op_b;
            endcase
          end
          OpcLoad, OpcStore: begin
            is_load_d = (opc == OpcLoad);
            wr_d      = (opc == OpcLoad);
            cnt_d     = '0;
            if (!f3[2]) begin
              if (IsPow2) begin
                baddr_d = (opc == OpcLoad) ? eff_i[AW-1:0] : eff_s[AW-1:0];
                state_d = (opc == OpcLoad) ? SLd : SSt;
              end else begin
                // reduce the byte address modulo the memory size
                mdu_req = '{start: 1'b1, op: MduDivU};
                mdu_a   = (opc == OpcLoad) ? eff_i : eff_s;
                mdu_b   = MemSize;
                state_d = SMaddr;
              end
            end
          end
          OpcBranch: begin
            if (taken) begin
              npc_d = pc_q + imm_b[31:0];
            end
          end
          OpcJal: begin
            wr_d  = 1'b1;
            val_d = {32'd0, pc_q + 32'd4};
            npc_d = pc_q + imm_j[31:0];
          end
          OpcJalr: begin
            if (rd == 5'd0 && rs1 == RegRa && rs1_val == 64'd0 && imm_i == 64'd0) begin
              stop_d = 1'b1;
            end else begin
              wr_d  = 1'b1;
              val_d = {32'd0, pc_q + 32'd4};
              npc_d = {eff_i[31:1], 1'b0};
            end
          end
          OpcLui: begin
            wr_d  = 1'b1;
            val_d = imm_u;
          end
          OpcAuipc: begin
            wr_d  = 1'b1;
            val_d = imm_u + {32'd0, pc_q};
          end
          OpcSystem: begin
            if (f3 == F3Priv && rd == 5'd0 && rs2[4:1] == 4'd0) begin
              stop_d = 1'b1;
            end
          end
          default: stop_d = 1'b1;
        endcase
      end

      SMdu: begin
        if (mdu_rsp.done) begin
          val_d = mdu_quo;
          x11_d = mdu_rem;
          state_d = is_mul_q ? SFin : SX11;
        end
      end

      SX11: begin
        rf_we    = 1'b1;
        rf_waddr = RegA1;
        rf_wdata = x11_q;
        state_d  = SFin;
      end

      SMaddr: begin
        if (mdu_rsp.done) begin
          baddr_d = mdu_rem[AW-1:0];
          state_d = is_load_q ? SLd : SSt;
        end
      end

      SLd: state_d = SLdw;

      SLdw: begin
        val_d   = merged;
        cnt_d   = cnt_q + 3'd1;
        baddr_d = addr_nxt;
        state_d = SLd;
        if (cnt_q == last_cnt) begin
          state_d = SFin;
          unique case (f3[1:0])
            2'd0:    val_d = {{56{merged[7]}}, merged[7:0]};
            2'd1:    val_d = {{48{merged[15]}}, merged[15:0]};
            2'd2:    val_d = {{32{merged[31]}}, merged[31:0]};
            default: val_d = merged;
          endcase
        end
      end

      SSt: begin
        dm_we   = 1'b1;
        cnt_d   = cnt_q + 3'd1;
        baddr_d = addr_nxt;
        if (cnt_q == last_cnt) begin
          state_d = SFin;
        end
      end

      SFin: begin
        if (commit) begin
          out_valid_d = 1'b1;
          state_d     = SIdle;
          if (stop_q) begin
            halt_d   = 1'b1;
            o_npc_d  = pc_q;
            o_halt_d = 1'b1;
            o_wr_d   = 1'b0;
            o_idx_d  = '0;
            o_val_d  = '0;
            o_a0_d   = a0_q;
          end else begin
            rf_we    = wr_q && (rd != 5'd0);
            pc_d     = npc_q;
            o_npc_d  = npc_q;
            o_halt_d = 1'b0;
            o_wr_d   = rf_we;
            o_idx_d  = rf_we ? rd : 5'd0;
            o_val_d  = rf_we ? val_q : 64'd0;
            if (rf_we && rd == RegA0) begin
              a0_d = val_q;
            end
            o_a0_d = a0_d;
          end
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      code_size_q <= '0;
      a0_q        <= '0;
      rf_valid_q  <= '0;
      baddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      a0_q        <= a0_d;
      baddr_q     <= baddr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        code_size_q <= cfg_wdata_i;
      end
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inst_q    <= inst_d;
    wr_q      <= wr_d;
    stop_q    <= stop_d;
    val_q     <= val_d;
    x11_q     <= x11_d;
    npc_q     <= npc_d;
    b_q       <= b_d;
    is_mul_q  <= is_mul_d;
    is_load_q <= is_load_d;
    cnt_q     <= cnt_d;
    o_npc_q   <= o_npc_d;
    o_halt_q  <= o_halt_d;
    o_wr_q    <= o_wr_d;
    o_idx_q   <= o_idx_d;
    o_val_q   <= o_val_d;
    o_a0_q    <= o_a0_d;
  end

  rvx_ram #(.WIDTH(64), .DEPTH(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr_a),
    .rdata_o (rdata_a)
  );

  rvx_ram #(.WIDTH(64), .DEPTH(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr_b),
    .rdata_o (rdata_b)
  );

  rvx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (baddr_q),
    .wdata_i (dm_wdata),
    .raddr_i (baddr_q),
    .rdata_o (dm_rdata)
  );

  rvx_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (mdu_a),
    .b_i    (mdu_b),
    .rsp_o  (mdu_rsp),
    .quo_o  (mdu_quo),
    .rem_o  (mdu_rem)
  );

  assign in_ready_o     = (state_q == SIdle);
  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = o_npc_q;
  assign halted_o       = o_halt_q;
  assign dest_written_o = o_wr_q;
  assign dest_index_o   = o_idx_q;
  assign dest_value_o   = o_val_q;
  assign return_value_o = o_a0_q;

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_waddr != 5'd0)
    else $error("write to x0");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q && $stable(pc_q))
    else $error("halt released or pc moved after halt");

  a_mdu_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_req.start |-> !mdu_rsp.busy)
    else $error("multiply/divide unit started while busy");

  a_halt_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> !dest_written_o)
    else $error("register write reported on halt");

  a_written_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dest_written_o |-> dest_index_o != 5'd0)
    else $error("write reported to x0");

endmodule

// ===== sv/rvx_ram.sv =====
module rvx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/rvx_mdu.sv =====
module rvx_mdu import rvx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mdu_req_t    req_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output mdu_rsp_t    rsp_o,
  output logic [63:0] quo_o,
  output logic [63:0] rem_o
);

  typedef enum logic [2:0] {
    MIdle = 3'b001,
    MRun  = 3'b010,
    MFix  = 3'b100
  } mdu_state_e;

  mdu_state_e  state_q, state_d;
  logic        is_mul_q, is_mul_d;
  logic        neg_quo_q, neg_quo_d;
  logic        neg_rem_q, neg_rem_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] x_q, x_d;
  logic [63:0] y_q, y_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic        is_signed, neg_a, neg_b;
  logic [64:0] rem_sh, diff;

  always_comb begin
    state_d   = state_q;
    is_mul_d  = is_mul_q;
    neg_quo_d = neg_quo_q;
    neg_rem_d = neg_rem_q;
    acc_d     = acc_q;
    x_d       = x_q;
    y_d       = y_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    quo_d     = quo_q;
    rem_d     = rem_q;
    is_signed = (req_i.op == MduDivS);
    neg_a     = is_signed & a_i[63];
    neg_b     = is_signed & b_i[63];
    rem_sh    = {acc_q, x_q[63]};
    diff      = rem_sh - {1'b0, y_q};
    unique case (state_q)
      MIdle: begin
        if (req_i.start) begin
          is_mul_d = (req_i.op == MduMul);
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = MRun;
          if (req_i.op == MduMul) begin
            x_d       = a_i;
            y_d       = b_i;
            neg_quo_d = 1'b0;
            neg_rem_d = 1'b0;
          end else begin
            x_d       = neg_a ? -a_i : a_i;
            y_d       = neg_b ? -b_i : b_i;
            neg_quo_d = neg_a ^ neg_b;
            neg_rem_d = neg_a;
          end
        end
      end
      MRun: begin
        if (is_mul_q) begin
          // shift-add, one multiplier bit a cycle
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[62:0], 1'b0};
          y_d = {1'b0, y_q[63:1]};
        end else begin
          // restoring division, one quotient bit a cycle
          acc_d = diff[64] ? rem_sh[63:0] : diff[63:0];
          x_d   = {x_q[62:0], ~diff[64]};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = MFix;
        end
      end
      MFix: begin
        quo_d   = is_mul_q ? acc_q : (neg_quo_q ? -x_q : x_q);
        rem_d   = neg_rem_q ? -acc_q : acc_q;
        done_d  = 1'b1;
        state_d = MIdle;
      end
      default: state_d = MIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_mul_q  <= is_mul_d;
    neg_quo_q <= neg_quo_d;
    neg_rem_q <= neg_rem_d;
    acc_q     <= acc_d;
    x_q       <= x_d;
    y_q       <= y_d;
    cnt_q     <= cnt_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
  end

  assign rsp_o.busy = (state_q != MIdle);
  assign rsp_o.done = done_q;
  assign quo_o      = quo_q;
  assign rem_o      = rem_q;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import rvx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MemSize = MemBytesDefault;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomPerPhase = 450;
  localparam int unsigned RandomPhases = 4;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        dest_written;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic [63:0] return_value;
  } exec_result_t;

  typedef struct {
    logic [31:0]  word;
    bit           typed;
    exec_result_t want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        instruction_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        next_pc_o;
  logic               halted_o;
  logic               dest_written_o;
  logic [4:0]         dest_index_o;
  logic signed [63:0] dest_value_o;
  logic signed [63:0] return_value_o;

  // architectural copy of the core
  logic [63:0] gpr [32];
  logic [7:0]  dmem [MemSize];
  logic [31:0] pc_q;
  bit          halt_q;
  logic [31:0] code_size_q;

  exec_result_t pending_results[$];
  int unsigned  err_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  rv64_integer_instruction_executor_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .instruction_i  (instruction_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_pc_o      (next_pc_o),
    .halted_o       (halted_o),
    .dest_written_o (dest_written_o),
    .dest_index_o   (dest_index_o),
    .dest_value_o   (dest_value_o),
    .return_value_o (return_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OpcOp};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpcStore};
  endfunction

  function automatic logic [63:0] load_bytes(logic [63:0] addr, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(dmem[(addr + 64'(i)) % MemSize]) << (8 * i);
    return v;
  endfunction

  // commit = 0 only evaluates the instruction, leaving the copy untouched
  function automatic exec_result_t execute_inst(logic [31:0] inst, bit commit);
    exec_result_t res;
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] a, b, imm, val, q, r, ua, ub, addr, off, v11, ld;
    logic [31:0] npc;
    bit          wr, stop, wr11, taken;
    op = inst[6:0];
    rd = inst[11:7];
    f3 = inst[14:12];
    rs1 = inst[19:15];
    rs2 = inst[24:20];
    f7 = inst[31:25];
    imm = {{52{inst[31]}}, inst[31:20]};
    res = '0;
    res.next_pc = pc_q;
    res.return_value = gpr[RegA0];
    if (halt_q) begin
      res.halted = 1'b1;
      return res;
    end
    if ({32'b0, pc_q} + 64'd4 > {32'b0, code_size_q}) begin
      if (commit) halt_q = 1'b1;
      res.halted = 1'b1;
      return res;
    end
    a = gpr[rs1];
    b = gpr[rs2];
    npc = pc_q + 32'd4;
    val = '0;
    v11 = '0;
    wr = 1'b0;
    stop = 1'b0;
    wr11 = 1'b0;
    case (op)
      OpcOp: begin
        wr = 1'b1;
        case (f3)
          F3AddSub: val = (f7 == F7Base) ? a + b : (f7 == F7Alt) ? a - b :
                          (f7 == F7MulDiv) ? a * b : '0;
          F3Sll:  val = a << b[5:0];
          F3Slt:  val = 64'($signed(a) < $signed(b));
          F3Sltu: val = 64'(a < b);
          F3Xor, F3Or: begin
            if (f7 == F7MulDiv || f7 == F7DivU) begin
              if (b == '0) begin
                val = (f3 == F3Xor) ? '1 : a;
                if (f3 == F3Xor) begin
                  wr11 = 1'b1;
                  v11 = a;
                end
              end else begin
                if (f7 == F7MulDiv) begin
                  ua = a[63] ? -a : a;
                  ub = b[63] ? -b : b;
                  q = ua / ub;
                  r = ua % ub;
                  if (a[63] != b[63]) q = -q;
                  if (a[63]) r = -r;
                end else begin
                  q = a / b;
                  r = a % b;
                end
                // the remainder form still returns the quotient
                val = q;
                wr11 = 1'b1;
                v11 = r;
              end
            end else begin
              val = (f3 == F3Xor) ? (a ^ b) : (a | b);
            end
          end
          F3Sr:   val = (f7 == F7Base) ? a >> b[5:0] : 64'($signed(a) >>> b[5:0]);
          default: val = a & b;
        endcase
      end
      OpcOpImm: begin
        wr = 1'b1;
        case (f3)
          F3AddSub: val = a + imm;
          F3Sll:  val = a << imm[5:0];
          F3Slt:  val = 64'($signed(a) < $signed(imm));
          F3Sltu: val = 64'(a < imm);
          F3Xor:  val = a ^ imm;
          F3Sr:   val = inst[30] ? 64'($signed(a) >>> imm[5:0]) : a >> imm[5:0];
          F3Or:   val = a | imm;
          default: val = a & imm;
        endcase
      end
      OpcLoad: begin
        wr = 1'b1;
        addr = a + imm;
        ld = load_bytes(addr, 8);
        case (f3)
          3'd0: val = {{56{ld[7]}}, ld[7:0]};
          3'd1: val = {{48{ld[15]}}, ld[15:0]};
          3'd2: val = {{32{ld[31]}}, ld[31:0]};
          3'd3: val = ld;
          default: val = '0;
        endcase
      end
      OpcStore: begin
        addr = a + {{52{inst[31]}}, inst[31:25], inst[11:7]};
        if (f3 < 3'd4 && commit)
          for (int i = 0; i < (1 << f3); i++) dmem[(addr + 64'(i)) % MemSize] = b[8*i +: 8];
      end
      OpcBranch: begin
        off = {{51{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        case (f3)
          F3Beq:  taken = (a == b);
          F3Bne:  taken = (a != b);
          F3Blt:  taken = $signed(a) < $signed(b);
          F3Bge:  taken = !($signed(a) < $signed(b));
          F3Bltu: taken = a < b;
          F3Bgeu: taken = a >= b;
          default: taken = 1'b0;
        endcase
        if (taken) npc = pc_q + off[31:0];
      end
      OpcJal: begin
        off = {{43{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        wr = 1'b1;
        val = {32'b0, npc};
        npc = pc_q + off[31:0];
      end
      OpcJalr: begin
        // return through a cleared ra ends the program
        if (rd == 5'd0 && rs1 == RegRa && a == '0 && imm == '0) begin
          stop = 1'b1;
        end else begin
          wr = 1'b1;
          val = {32'b0, npc};
          addr = a + imm;
          npc = {addr[31:1], 1'b0};
        end
      end
      OpcLui:   begin
        wr = 1'b1;
        val = {{32{inst[31]}}, inst[31:12], 12'b0};
      end
      OpcAuipc: begin
        wr = 1'b1;
        val = {{32{inst[31]}}, inst[31:12], 12'b0} + {32'b0, pc_q};
      end
      OpcSystem: if (f3 == F3Priv && rd == 5'd0 && rs2 <= 5'd1) stop = 1'b1;
      default: stop = 1'b1;
    endcase
    if (stop) begin
      if (commit) halt_q = 1'b1;
      res.halted = 1'b1;
      return res;
    end
    if (commit) begin
      if (wr11) gpr[RegA1] = v11;
      if (wr && rd != 5'd0) gpr[rd] = val;
      pc_q = npc;
    end
    res.next_pc = npc;
    res.dest_written = wr && rd != 5'd0;
    res.dest_index = res.dest_written ? rd : 5'd0;
    res.dest_value = res.dest_written ? val : '0;
    res.return_value = gpr[RegA0];
    return res;
  endfunction

  function automatic logic [31:0] gen_inst();
    logic [31:0] w;
    logic [6:0]  f7;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: f7 = F7Base;
      1: f7 = F7Alt;
      2: f7 = F7MulDiv;
      3: f7 = F7DivU;
      default: f7 = w[31:25];
    endcase
    case ($urandom_range(0, 12))
      0, 1: w = {f7, w[24:7], OpcOp};
      2, 3: w[6:0] = OpcOpImm;
      4, 5: begin
        w[6:0] = OpcLoad;
        w[14] = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 1) == 1) w[19:15] = 5'd0;
      end
      6, 7: begin
        w[6:0] = OpcStore;
        w[14] = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 1) == 1) w[19:15] = 5'd0;
      end
      8: w[6:0] = OpcBranch;
      9: w[6:0] = ($urandom_range(0, 1) == 1) ? OpcJal : OpcJalr;
      10: w[6:0] = ($urandom_range(0, 1) == 1) ? OpcLui : OpcAuipc;
      11: w[6:0] = OpcSystem;
      default: ;
    endcase
    return w;
  endfunction

  // keep the program running: redraw anything that would end it
  function automatic logic [31:0] pick_running_inst();
    logic [31:0]  w;
    exec_result_t r;
    w = '0;
    for (int t = 0; t < 200; t++) begin
      w = gen_inst();
      r = execute_inst(w, 1'b0);
      if (!r.halted) return w;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  task automatic send_request(logic [31:0] word, bit typed, exec_result_t want);
    exec_result_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    instruction_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    r = execute_inst(word, 1'b1);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_code_size(logic [31:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    code_size_q = v;
  endtask

  always @(posedge clk_i) begin
    exec_result_t e;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {32'b0, next_pc_o}, '0);
      end else begin
        e = pending_results.pop_front();
        if (next_pc_o !== e.next_pc) report_mismatch("next_pc", next_pc_o, e.next_pc);
        if (halted_o !== e.halted) report_mismatch("halted", halted_o, e.halted);
        if (dest_written_o !== e.dest_written)
          report_mismatch("dest_written", dest_written_o, e.dest_written);
        if (dest_index_o !== e.dest_index)
          report_mismatch("dest_index", dest_index_o, e.dest_index);
        if (dest_value_o !== e.dest_value)
          report_mismatch("dest_value", dest_value_o, e.dest_value);
        if (return_value_o !== e.return_value)
          report_mismatch("return_value", return_value_o, e.return_value);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    stim_row_t    rows[$];
    exec_result_t none;
    logic [63:0]  lo;
    none = '0;
    foreach (gpr[i]) gpr[i] = '0;
    gpr[RegSp] = MemSize;
    foreach (dmem[i]) dmem[i] = '0;
    pc_q = '0;
    halt_q = 1'b0;
    code_size_q = '0;

    rows.push_back('{enc_i(12'd0, 5'd0, F3AddSub, 5'd0, OpcOpImm), 1'b1,
                     exec_result_t'{32'd4, 1'b0, 1'b0, 5'd0, 64'd0, 64'd0}});
    rows.push_back('{{20'h80000, RegA0, OpcLui}, 1'b1,
                     exec_result_t'{32'd8, 1'b0, 1'b1, RegA0, 64'hFFFFFFFF80000000,
                                    64'hFFFFFFFF80000000}});
    rows.push_back('{enc_i(12'hFFF, 5'd0, F3AddSub, RegA1, OpcOpImm), 1'b1,
                     exec_result_t'{32'd12, 1'b0, 1'b1, RegA1, '1, 64'hFFFFFFFF80000000}});
    // most negative value over -1, then the divide-by-zero forms
    rows.push_back('{enc_i(12'd1, 5'd0, F3AddSub, 5'd5, OpcOpImm), 1'b0, none});
    rows.push_back('{enc_i(12'd63, 5'd5, F3Sll, 5'd5, OpcOpImm), 1'b0, none});
    rows.push_back('{enc_r(F7MulDiv, RegA1, 5'd5, F3Xor, 5'd7), 1'b0, none});
    rows.push_back('{enc_r(F7DivU, 5'd5, RegA1, F3Xor, 5'd8), 1'b0, none});
    rows.push_back('{enc_r(F7MulDiv, 5'd8, RegA0, F3Or, 5'd9), 1'b0, none});
    rows.push_back('{enc_r(F7DivU, 5'd9, RegA0, F3Or, 5'd12), 1'b0, none});
    rows.push_back('{enc_r(F7MulDiv, 5'd0, 5'd5, F3Xor, 5'd13), 1'b0, none});
    rows.push_back('{enc_r(F7DivU, 5'd0, 5'd5, F3Or, 5'd14), 1'b0, none});
    rows.push_back('{enc_r(F7MulDiv, RegA1, RegA0, F3AddSub, 5'd16), 1'b0, none});
    rows.push_back('{enc_r(F7Alt, 5'd5, RegA0, F3AddSub, 5'd15), 1'b0, none});
    rows.push_back('{enc_r(F7Alt, 5'd9, RegA0, F3Sr, 5'd17), 1'b0, none});
    rows.push_back('{enc_r(F7Base, 5'd9, RegA0, F3Sltu, 5'd18), 1'b0, none});
    rows.push_back('{enc_i(12'h404, RegA0, F3Sr, 5'd19, OpcOpImm), 1'b0, none});
    rows.push_back('{enc_s(12'd8, RegA0, 5'd0, 3'd3), 1'b0, none});
    rows.push_back('{enc_s(12'hFFF, 5'd5, 5'd0, 3'd0), 1'b0, none});
    rows.push_back('{enc_i(12'hFFE, 5'd0, 3'd2, 5'd20, OpcLoad), 1'b0, none});
    rows.push_back('{enc_i(12'd11, 5'd0, 3'd1, 5'd21, OpcLoad), 1'b0, none});
    rows.push_back('{enc_i(12'd8, 5'd0, 3'd3, 5'd22, OpcLoad), 1'b0, none});
    rows.push_back('{32'h00000463, 1'b0, none});               // beq x0, x0, +8
    rows.push_back('{32'h008000EF, 1'b0, none});               // jal ra, +8
    rows.push_back('{32'h00008067, 1'b0, none});               // ret through a live ra
    rows.push_back('{{20'hFFFFF, 5'd23, OpcAuipc}, 1'b0, none});
    rows.push_back('{{12'h001, 5'd0, 3'd2, 5'd3, OpcSystem}, 1'b0, none});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_code_size('1);
    foreach (rows[i]) send_request(rows[i].word, rows[i].typed, rows[i].want);

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        write_code_size('1);
      end else begin
        wait_idle();
        lo = {32'b0, pc_q} + 64'd4;
        if (lo > 64'hFFFFFFFF) lo = 64'hFFFFFFFF;
        write_code_size(32'(lo + ({$urandom, $urandom} % (64'h1_0000_0000 - lo))));
      end
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (p == RandomPhases - 1 && n > RandomPerPhase / 2) calm = 1'b1;
        send_request(pick_running_inst(), 1'b0, none);
      end
    end

    // end the program by one of its stop conditions
    case ($urandom_range(0, 4))
      0: send_request({12'h000, 5'd0, F3Priv, 5'd0, OpcSystem}, 1'b0, none);
      1: send_request({12'h001, 5'd0, F3Priv, 5'd0, OpcSystem}, 1'b0, none);
      2: send_request({25'($urandom_range(0, 32'h1FFFFFF)), 7'h7F}, 1'b0, none);
      3: begin
        send_request(enc_i(12'd0, 5'd0, F3AddSub, RegRa, OpcOpImm), 1'b0, none);
        send_request(32'h00008067, 1'b0, none);
      end
      default: write_code_size(pc_q);
    endcase
    write_code_size('0);
    for (int n = 0; n < 4; n++) send_request($urandom, 1'b0, none);

    wait_idle();
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rvx_pkg.sv
sv/rvx_ram.sv
sv/rvx_mdu.sv
sv/rv64_integer_instruction_executor_core.sv
tb/sv/tb_top.sv
